/* design/hfe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfe_pkg
// Shared widths, pipeline depths, product and term indexes, and types for the
// homography focal estimate pipeline.
// ----------------------------------------------------------------------------
package hfe_pkg;

  localparam int IN_W   = 64;   // one matrix entry, signed Q24.40
  localparam int HALF_W = 32;   // partial product operand width
  localparam int MAG_W  = 128;  // magnitude of a product or of a sum
  localparam int SUM_W  = 130;  // signed sum of up to four products
  localparam int FRAC_W = 40;   // fraction bits of the fixed-point format
  localparam int QUO_W  = 86;   // quotient width, Q46.40
  localparam int SAT_SH = QUO_W - FRAC_W;
  localparam int RAD_W  = 126;  // square-root radicand width
  localparam int ROOT_W = 63;   // square-root result width
  localparam int REM_W  = ROOT_W + 3;

  localparam int DIV_STAGES  = QUO_W;
  localparam int DIV_LAT     = DIV_STAGES + 1;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int SQRT_LAT    = SQRT_STAGES + 1;
  // start edge to done edge: six front stages, divider, pick, two square
  // roots, two product stages and the output register
  localparam int PIPE_LAT    = 10 + DIV_LAT + 2 * SQRT_LAT;

  localparam int NUM_ENT  = 8;
  localparam int NUM_PROD = 14;
  localparam int NUM_SIDE = 2;
  localparam int NUM_TERM = 4;
  localparam int NUM_PP   = 4;

  // terms of one side
  localparam int T_N1 = 0;
  localparam int T_D1 = 1;
  localparam int T_N2 = 2;
  localparam int T_D2 = 3;

  // sides
  localparam int SIDE0 = 0;
  localparam int SIDE1 = 1;

  // products of entry pairs (entries 0..7 are h00 h01 h02 h10 h11 h12 h20 h21)
  localparam int P_67 = 0;
  localparam int P_77 = 1;
  localparam int P_66 = 2;
  localparam int P_01 = 3;
  localparam int P_34 = 4;
  localparam int P_00 = 5;
  localparam int P_33 = 6;
  localparam int P_11 = 7;
  localparam int P_44 = 8;
  localparam int P_03 = 9;
  localparam int P_14 = 10;
  localparam int P_25 = 11;
  localparam int P_55 = 12;
  localparam int P_22 = 13;

  localparam logic [2:0] PROD_A [NUM_PROD] = '{
    3'd6, 3'd7, 3'd6, 3'd0, 3'd3, 3'd0, 3'd3,
    3'd1, 3'd4, 3'd0, 3'd1, 3'd2, 3'd5, 3'd2
  };
  localparam logic [2:0] PROD_B [NUM_PROD] = '{
    3'd7, 3'd7, 3'd6, 3'd1, 3'd4, 3'd0, 3'd3,
    3'd1, 3'd4, 3'd3, 3'd4, 3'd5, 3'd5, 3'd2
  };

  typedef logic        [IN_W-1:0]     ent_t;
  typedef logic        [2*HALF_W-1:0] pp_t;
  typedef logic        [MAG_W-1:0]    mag_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic        [QUO_W-1:0]    quo_t;
  typedef logic        [RAD_W-1:0]    rad_t;
  typedef logic        [ROOT_W-1:0]   root_t;
  typedef logic        [REM_W-1:0]    rem_t;

  localparam quo_t SAT_Q = '1;

  // per-side flags that travel beside the dividers
  typedef struct packed {
    logic pos1;  // candidate 1 positive
    logic pos2;  // candidate 2 positive
    logic sat1;  // candidate 1 quotient saturates
    logic sat2;  // candidate 2 quotient saturates
    logic dgt;   // |d1| > |d2|
  } side_tag_t;

  typedef struct packed {
    logic                       vld;
    side_tag_t [NUM_SIDE-1:0]   side;
  } div_tag_t;

endpackage

/* design/hfe_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfe_div
// Pipelined restoring divider: floor(num * 2^40 / den), one quotient bit per
// stage. Only meaningful when the quotient stays below 2^86.
// ----------------------------------------------------------------------------
module hfe_div (
  input  logic          clk,
  input  hfe_pkg::mag_t num,
  input  hfe_pkg::mag_t den,
  output hfe_pkg::quo_t quo
);

  hfe_pkg::mag_t rem_q [hfe_pkg::DIV_STAGES];
  hfe_pkg::mag_t den_q [hfe_pkg::DIV_STAGES];
  logic [hfe_pkg::SAT_SH-1:0] nb_q [hfe_pkg::DIV_STAGES];
  hfe_pkg::quo_t quo_q [hfe_pkg::DIV_STAGES+1];

  // Load the upper dividend bits as the first partial remainder.
  always_ff @(posedge clk) begin
    rem_q[0] <= {{hfe_pkg::SAT_SH{1'b0}}, num[hfe_pkg::MAG_W-1:hfe_pkg::SAT_SH]};
    den_q[0] <= den;
    nb_q[0]  <= num[hfe_pkg::SAT_SH-1:0];
    quo_q[0] <= '0;
  end

  for (genvar k = 0; k < hfe_pkg::DIV_STAGES; k++) begin : g_stage
    logic [hfe_pkg::MAG_W:0] sh;
    logic [hfe_pkg::MAG_W:0] diff;
    logic                    ge;

    assign sh   = {rem_q[k], nb_q[k][hfe_pkg::SAT_SH-1]};
    assign diff = sh - {1'b0, den_q[k]};
    assign ge   = ~diff[hfe_pkg::MAG_W];

    always_ff @(posedge clk) begin
      quo_q[k+1] <= {quo_q[k][hfe_pkg::QUO_W-2:0], ge};
    end

    if (k + 1 < hfe_pkg::DIV_STAGES) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[k+1] <= ge ? diff[hfe_pkg::MAG_W-1:0] : sh[hfe_pkg::MAG_W-1:0];
        den_q[k+1] <= den_q[k];
        nb_q[k+1]  <= {nb_q[k][hfe_pkg::SAT_SH-2:0], 1'b0};
      end
    end
  end

  assign quo = quo_q[hfe_pkg::DIV_STAGES];

endmodule

/* design/hfe_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfe_sqrt
// Pipelined digit-by-digit integer square root: floor(sqrt(rad)), one root
// bit per stage.
// ----------------------------------------------------------------------------
module hfe_sqrt (
  input  logic           clk,
  input  hfe_pkg::rad_t  rad,
  output hfe_pkg::root_t root
);

  hfe_pkg::rem_t  rem_q  [hfe_pkg::SQRT_STAGES];
  hfe_pkg::rad_t  rad_q  [hfe_pkg::SQRT_STAGES];
  hfe_pkg::root_t root_q [hfe_pkg::SQRT_STAGES+1];

  always_ff @(posedge clk) begin
    rem_q[0]  <= '0;
    rad_q[0]  <= rad;
    root_q[0] <= '0;
  end

  for (genvar k = 0; k < hfe_pkg::SQRT_STAGES; k++) begin : g_stage
    logic [hfe_pkg::REM_W+1:0] cur;
    logic [hfe_pkg::REM_W+1:0] trial;
    logic [hfe_pkg::REM_W+1:0] diff;
    logic                      ge;

    assign cur   = {rem_q[k], rad_q[k][hfe_pkg::RAD_W-1 -: 2]};
    assign trial = {{(hfe_pkg::REM_W-hfe_pkg::ROOT_W){1'b0}}, root_q[k], 2'b01};
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      root_q[k+1] <= {root_q[k][hfe_pkg::ROOT_W-2:0], ge};
    end

    if (k + 1 < hfe_pkg::SQRT_STAGES) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[k+1] <= ge ? diff[hfe_pkg::REM_W-1:0] : cur[hfe_pkg::REM_W-1:0];
        rad_q[k+1] <= {rad_q[k][hfe_pkg::RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[hfe_pkg::SQRT_STAGES];

endmodule

/* design/homography_focal_estimate_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homography_focal_estimate_unit
// Focal-length estimate from the first eight entries of a 3x3 homography.
// ----------------------------------------------------------------------------
// A fully pipelined unit: it takes one transaction in every clock cycle and
// never raises busy. Each result sits on focal/valid_res for one cycle with
// done high. The pipeline depth is set by the 86-stage divider (one quotient
// bit a stage) and the two 63-stage square roots in series (per-side focal,
// then the geometric mean). The receiver cannot stall, so results are never
// held back; results leave in the order their transactions entered.
// focal is unsigned Q23.40 and reads 0 with valid_res low when either side
// has no positive focal-square candidate.
// ----------------------------------------------------------------------------
module homography_focal_estimate_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [hfe_pkg::IN_W-1:0]  h00,
  input  logic signed [hfe_pkg::IN_W-1:0]  h01,
  input  logic signed [hfe_pkg::IN_W-1:0]  h02,
  input  logic signed [hfe_pkg::IN_W-1:0]  h10,
  input  logic signed [hfe_pkg::IN_W-1:0]  h11,
  input  logic signed [hfe_pkg::IN_W-1:0]  h12,
  input  logic signed [hfe_pkg::IN_W-1:0]  h20,
  input  logic signed [hfe_pkg::IN_W-1:0]  h21,
  output logic                             done,
  output logic [hfe_pkg::ROOT_W-1:0]       focal,
  output logic                             valid_res
);

  // The pipeline never stalls.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: entry magnitudes and signs
  // --------------------------------------------------------------------------
  hfe_pkg::ent_t ent_in [hfe_pkg::NUM_ENT];
  assign ent_in[0] = h00;
  assign ent_in[1] = h01;
  assign ent_in[2] = h02;
  assign ent_in[3] = h10;
  assign ent_in[4] = h11;
  assign ent_in[5] = h12;
  assign ent_in[6] = h20;
  assign ent_in[7] = h21;

  hfe_pkg::ent_t                mag1 [hfe_pkg::NUM_ENT];
  logic [hfe_pkg::NUM_ENT-1:0]  neg1;
  logic                         v1;

  always_ff @(posedge clk) begin
    for (int e = 0; e < hfe_pkg::NUM_ENT; e++) begin
      mag1[e] <= ent_in[e][hfe_pkg::IN_W-1] ? (~ent_in[e] + 1'b1) : ent_in[e];
      neg1[e] <= ent_in[e][hfe_pkg::IN_W-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: 32x32 partial products of each PROD_A/PROD_B entry pair
  // --------------------------------------------------------------------------
  hfe_pkg::pp_t                 pp2 [hfe_pkg::NUM_PROD][hfe_pkg::NUM_PP];
  logic [hfe_pkg::NUM_PROD-1:0] psg2;
  logic                         v2;

  always_ff @(posedge clk) begin
    for (int p = 0; p < hfe_pkg::NUM_PROD; p++) begin
      pp2[p][0] <= mag1[hfe_pkg::PROD_A[p]][hfe_pkg::HALF_W-1:0] *
                   mag1[hfe_pkg::PROD_B[p]][hfe_pkg::HALF_W-1:0];
      pp2[p][1] <= mag1[hfe_pkg::PROD_A[p]][hfe_pkg::HALF_W-1:0] *
                   mag1[hfe_pkg::PROD_B[p]][hfe_pkg::IN_W-1:hfe_pkg::HALF_W];
      pp2[p][2] <= mag1[hfe_pkg::PROD_A[p]][hfe_pkg::IN_W-1:hfe_pkg::HALF_W] *
                   mag1[hfe_pkg::PROD_B[p]][hfe_pkg::HALF_W-1:0];
      pp2[p][3] <= mag1[hfe_pkg::PROD_A[p]][hfe_pkg::IN_W-1:hfe_pkg::HALF_W] *
                   mag1[hfe_pkg::PROD_B[p]][hfe_pkg::IN_W-1:hfe_pkg::HALF_W];
      psg2[p]   <= neg1[hfe_pkg::PROD_A[p]] ^ neg1[hfe_pkg::PROD_B[p]];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: assemble the 128-bit product magnitudes
  // --------------------------------------------------------------------------
  hfe_pkg::mag_t                pm3 [hfe_pkg::NUM_PROD];
  logic [hfe_pkg::NUM_PROD-1:0] psg3;
  logic                         v3;

  always_ff @(posedge clk) begin
    for (int p = 0; p < hfe_pkg::NUM_PROD; p++) begin
      pm3[p] <= hfe_pkg::mag_t'(pp2[p][0]) +
                (hfe_pkg::mag_t'(pp2[p][1]) << hfe_pkg::HALF_W) +
                (hfe_pkg::mag_t'(pp2[p][2]) << hfe_pkg::HALF_W) +
                (hfe_pkg::mag_t'(pp2[p][3]) << (2 * hfe_pkg::HALF_W));
    end
    psg3 <= psg2;
  end

  // --------------------------------------------------------------------------
  // Stage 4: signed products
  // --------------------------------------------------------------------------
  hfe_pkg::sum_t ps4 [hfe_pkg::NUM_PROD];
  logic          v4;

  always_ff @(posedge clk) begin
    for (int p = 0; p < hfe_pkg::NUM_PROD; p++) begin
      ps4[p] <= psg3[p] ? -hfe_pkg::sum_t'(pm3[p]) : hfe_pkg::sum_t'(pm3[p]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: numerators and denominators of both sides
  // --------------------------------------------------------------------------
  hfe_pkg::sum_t sm5 [hfe_pkg::NUM_SIDE][hfe_pkg::NUM_TERM];
  logic          v5;

  always_ff @(posedge clk) begin
    sm5[hfe_pkg::SIDE1][hfe_pkg::T_N1] <= -(ps4[hfe_pkg::P_01] + ps4[hfe_pkg::P_34]);
    sm5[hfe_pkg::SIDE1][hfe_pkg::T_D1] <= ps4[hfe_pkg::P_67];
    sm5[hfe_pkg::SIDE1][hfe_pkg::T_N2] <= ps4[hfe_pkg::P_00] + ps4[hfe_pkg::P_33]
                                        - ps4[hfe_pkg::P_11] - ps4[hfe_pkg::P_44];
    sm5[hfe_pkg::SIDE1][hfe_pkg::T_D2] <= ps4[hfe_pkg::P_77] - ps4[hfe_pkg::P_66];
    sm5[hfe_pkg::SIDE0][hfe_pkg::T_N1] <= -ps4[hfe_pkg::P_25];
    sm5[hfe_pkg::SIDE0][hfe_pkg::T_D1] <= ps4[hfe_pkg::P_03] + ps4[hfe_pkg::P_14];
    sm5[hfe_pkg::SIDE0][hfe_pkg::T_N2] <= ps4[hfe_pkg::P_55] - ps4[hfe_pkg::P_22];
    sm5[hfe_pkg::SIDE0][hfe_pkg::T_D2] <= ps4[hfe_pkg::P_00] + ps4[hfe_pkg::P_11]
                                        - ps4[hfe_pkg::P_33] - ps4[hfe_pkg::P_44];
  end

  // --------------------------------------------------------------------------
  // Stage 6: sign/magnitude form and candidate positivity
  // --------------------------------------------------------------------------
  hfe_pkg::mag_t mag6 [hfe_pkg::NUM_SIDE][hfe_pkg::NUM_TERM];
  logic [1:0]    pos6 [hfe_pkg::NUM_SIDE];
  logic          v6;

  always_ff @(posedge clk) begin
    for (int s = 0; s < hfe_pkg::NUM_SIDE; s++) begin
      for (int t = 0; t < hfe_pkg::NUM_TERM; t++) begin
        mag6[s][t] <= sm5[s][t][hfe_pkg::SUM_W-1] ?
                      hfe_pkg::mag_t'(-sm5[s][t]) : hfe_pkg::mag_t'(sm5[s][t]);
      end
      // positive: both nonzero and of equal sign
      pos6[s][0] <= (sm5[s][hfe_pkg::T_N1] != '0) && (sm5[s][hfe_pkg::T_D1] != '0) &&
                    (sm5[s][hfe_pkg::T_N1][hfe_pkg::SUM_W-1] ==
                     sm5[s][hfe_pkg::T_D1][hfe_pkg::SUM_W-1]);
      pos6[s][1] <= (sm5[s][hfe_pkg::T_N2] != '0) && (sm5[s][hfe_pkg::T_D2] != '0) &&
                    (sm5[s][hfe_pkg::T_N2][hfe_pkg::SUM_W-1] ==
                     sm5[s][hfe_pkg::T_D2][hfe_pkg::SUM_W-1]);
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // --------------------------------------------------------------------------
  // Dividers: one per candidate; flags ride alongside in a tag line
  // --------------------------------------------------------------------------
  hfe_pkg::quo_t     quo [hfe_pkg::NUM_SIDE][2];
  hfe_pkg::div_tag_t tag_in;
  hfe_pkg::div_tag_t tag [hfe_pkg::DIV_LAT];

  for (genvar s = 0; s < hfe_pkg::NUM_SIDE; s++) begin : g_side
    hfe_div u_div1 (
      .clk (clk),
      .num (mag6[s][hfe_pkg::T_N1]),
      .den (mag6[s][hfe_pkg::T_D1]),
      .quo (quo[s][0])
    );
    hfe_div u_div2 (
      .clk (clk),
      .num (mag6[s][hfe_pkg::T_N2]),
      .den (mag6[s][hfe_pkg::T_D2]),
      .quo (quo[s][1])
    );
  end

  // Saturate when num >= den * 2^46, i.e. when the quotient reaches 2^86.
  always_comb begin
    tag_in.vld = v6;
    for (int s = 0; s < hfe_pkg::NUM_SIDE; s++) begin
      tag_in.side[s].pos1 = pos6[s][0];
      tag_in.side[s].pos2 = pos6[s][1];
      tag_in.side[s].sat1 =
        {{hfe_pkg::SAT_SH{1'b0}}, mag6[s][hfe_pkg::T_N1]} >=
        {mag6[s][hfe_pkg::T_D1], {hfe_pkg::SAT_SH{1'b0}}};
      tag_in.side[s].sat2 =
        {{hfe_pkg::SAT_SH{1'b0}}, mag6[s][hfe_pkg::T_N2]} >=
        {mag6[s][hfe_pkg::T_D2], {hfe_pkg::SAT_SH{1'b0}}};
      tag_in.side[s].dgt  = mag6[s][hfe_pkg::T_D1] > mag6[s][hfe_pkg::T_D2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < hfe_pkg::DIV_LAT; j++) begin
        tag[j] <= '0;
      end
    end else begin
      tag[0] <= tag_in;
      for (int j = 1; j < hfe_pkg::DIV_LAT; j++) begin
        tag[j] <= tag[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: clamp, pick one candidate per side, scale into the radicand
  // --------------------------------------------------------------------------
  hfe_pkg::div_tag_t tag_out;
  hfe_pkg::quo_t     cv   [hfe_pkg::NUM_SIDE][2];
  hfe_pkg::quo_t     pick [hfe_pkg::NUM_SIDE];
  logic [hfe_pkg::NUM_SIDE-1:0] side_ok;

  assign tag_out = tag[hfe_pkg::DIV_LAT-1];

  always_comb begin
    for (int s = 0; s < hfe_pkg::NUM_SIDE; s++) begin
      cv[s][0] = tag_out.side[s].sat1 ? hfe_pkg::SAT_Q : quo[s][0];
      cv[s][1] = tag_out.side[s].sat2 ? hfe_pkg::SAT_Q : quo[s][1];
      side_ok[s] = tag_out.side[s].pos1 | tag_out.side[s].pos2;
      if (tag_out.side[s].pos1 && tag_out.side[s].pos2) begin
        // both positive: larger |d1| takes the larger value
        if (tag_out.side[s].dgt == (cv[s][0] >= cv[s][1])) begin
          pick[s] = cv[s][0];
        end else begin
          pick[s] = cv[s][1];
        end
      end else if (tag_out.side[s].pos1) begin
        pick[s] = cv[s][0];
      end else begin
        pick[s] = cv[s][1];
      end
    end
  end

  hfe_pkg::rad_t x8 [hfe_pkg::NUM_SIDE];
  logic          ok8;
  logic          v8;

  always_ff @(posedge clk) begin
    for (int s = 0; s < hfe_pkg::NUM_SIDE; s++) begin
      x8[s] <= {pick[s], {hfe_pkg::FRAC_W{1'b0}}};
    end
    ok8 <= &side_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= tag_out.vld;
    end
  end

  // --------------------------------------------------------------------------
  // Per-side focal: square root of the picked value
  // --------------------------------------------------------------------------
  hfe_pkg::root_t fs [hfe_pkg::NUM_SIDE];

  for (genvar s = 0; s < hfe_pkg::NUM_SIDE; s++) begin : g_froot
    hfe_sqrt u_sqrt (
      .clk  (clk),
      .rad  (x8[s]),
      .root (fs[s])
    );
  end

  logic [hfe_pkg::SQRT_LAT-1:0] okl_a;
  logic [hfe_pkg::SQRT_LAT-1:0] vl_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vl_a <= '0;
    end else begin
      vl_a <= {vl_a[hfe_pkg::SQRT_LAT-2:0], v8};
    end
    okl_a <= {okl_a[hfe_pkg::SQRT_LAT-2:0], ok8};
  end

  // --------------------------------------------------------------------------
  // Stages 9-10: product of the two side focals
  // --------------------------------------------------------------------------
  hfe_pkg::pp_t  pp9 [hfe_pkg::NUM_PP];
  logic          ok9;
  logic          v9;
  hfe_pkg::rad_t prod10;
  logic          ok10;
  logic          v10;

  always_ff @(posedge clk) begin
    pp9[0] <= fs[hfe_pkg::SIDE1][hfe_pkg::HALF_W-1:0] *
              fs[hfe_pkg::SIDE0][hfe_pkg::HALF_W-1:0];
    pp9[1] <= fs[hfe_pkg::SIDE1][hfe_pkg::HALF_W-1:0] *
              fs[hfe_pkg::SIDE0][hfe_pkg::ROOT_W-1:hfe_pkg::HALF_W];
    pp9[2] <= fs[hfe_pkg::SIDE1][hfe_pkg::ROOT_W-1:hfe_pkg::HALF_W] *
              fs[hfe_pkg::SIDE0][hfe_pkg::HALF_W-1:0];
    pp9[3] <= fs[hfe_pkg::SIDE1][hfe_pkg::ROOT_W-1:hfe_pkg::HALF_W] *
              fs[hfe_pkg::SIDE0][hfe_pkg::ROOT_W-1:hfe_pkg::HALF_W];
    ok9    <= okl_a[hfe_pkg::SQRT_LAT-1];
    prod10 <= hfe_pkg::rad_t'(hfe_pkg::mag_t'(pp9[0]) +
                              (hfe_pkg::mag_t'(pp9[1]) << hfe_pkg::HALF_W) +
                              (hfe_pkg::mag_t'(pp9[2]) << hfe_pkg::HALF_W) +
                              (hfe_pkg::mag_t'(pp9[3]) << (2 * hfe_pkg::HALF_W)));
    ok10   <= ok9;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else begin
      v9  <= vl_a[hfe_pkg::SQRT_LAT-1];
      v10 <= v9;
    end
  end

  // --------------------------------------------------------------------------
  // Geometric mean and output register
  // --------------------------------------------------------------------------
  hfe_pkg::root_t gm;

  hfe_sqrt u_sqrt_gm (
    .clk  (clk),
    .rad  (prod10),
    .root (gm)
  );

  logic [hfe_pkg::SQRT_LAT-1:0] okl_b;
  logic [hfe_pkg::SQRT_LAT-1:0] vl_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vl_b <= '0;
      done <= 1'b0;
    end else begin
      vl_b <= {vl_b[hfe_pkg::SQRT_LAT-2:0], v10};
      done <= vl_b[hfe_pkg::SQRT_LAT-1];
    end
    okl_b     <= {okl_b[hfe_pkg::SQRT_LAT-2:0], ok10};
    // drop the estimate when either side had no positive candidate
    focal     <= okl_b[hfe_pkg::SQRT_LAT-1] ? gm : '0;
    valid_res <= okl_b[hfe_pkg::SQRT_LAT-1];
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Every accepted transaction yields a result after the fixed latency.
  a_fixed_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(hfe_pkg::PIPE_LAT) done)
    else $error("accepted transaction did not complete after the pipeline latency");

  // No result appears without a transaction accepted at the right time.
  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, hfe_pkg::PIPE_LAT))
    else $error("result strobe without a matching accepted transaction");

endmodule

/* sim/hfe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfe_checker
// Watches the command and result channels of the focal estimate unit,
// predicts each result from the accepted matrix entries and compares.
// ----------------------------------------------------------------------------
module hfe_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [hfe_pkg::IN_W-1:0]     h00,
  input  logic [hfe_pkg::IN_W-1:0]     h01,
  input  logic [hfe_pkg::IN_W-1:0]     h02,
  input  logic [hfe_pkg::IN_W-1:0]     h10,
  input  logic [hfe_pkg::IN_W-1:0]     h11,
  input  logic [hfe_pkg::IN_W-1:0]     h12,
  input  logic [hfe_pkg::IN_W-1:0]     h20,
  input  logic [hfe_pkg::IN_W-1:0]     h21,
  input  logic                         done,
  input  logic [hfe_pkg::ROOT_W-1:0]   focal,
  input  logic                         valid_res,
  output int                           errors,
  output int                           pending
);

  typedef struct packed {
    logic [hfe_pkg::ROOT_W-1:0] focal;
    logic                       vld;
  } focal_res_t;

  focal_res_t focal_q[$];

  localparam logic [hfe_pkg::QUO_W-1:0] QSAT = '1;

  function automatic logic signed [hfe_pkg::SUM_W-1:0] prod(
      logic [hfe_pkg::IN_W-1:0] a, logic [hfe_pkg::IN_W-1:0] b);
    logic signed [hfe_pkg::SUM_W-1:0] sa, sb;
    sa = {{(hfe_pkg::SUM_W-hfe_pkg::IN_W){a[hfe_pkg::IN_W-1]}}, a};
    sb = {{(hfe_pkg::SUM_W-hfe_pkg::IN_W){b[hfe_pkg::IN_W-1]}}, b};
    return sa * sb;
  endfunction

  function automatic logic [hfe_pkg::ROOT_W-1:0] isqrt(logic [hfe_pkg::RAD_W-1:0] x);
    logic [hfe_pkg::ROOT_W-1:0] r, c;
    r = '0;
    for (int b = hfe_pkg::ROOT_W - 1; b >= 0; b--) begin
      c = r | (63'd1 << b);
      if ({{hfe_pkg::RAD_W{1'b0}}, c} * {{hfe_pkg::RAD_W{1'b0}}, c} <=
          {{hfe_pkg::RAD_W{1'b0}}, x}) r = c;
    end
    return r;
  endfunction

  // floor(|n| * 2^40 / |d|) saturated; valid only when signs match and nonzero
  function automatic logic ratio(logic signed [hfe_pkg::SUM_W-1:0] n,
                                 logic signed [hfe_pkg::SUM_W-1:0] d,
                                 output logic [hfe_pkg::QUO_W-1:0] v);
    logic [hfe_pkg::SUM_W-1:0] an, ad;
    logic [hfe_pkg::SUM_W+hfe_pkg::FRAC_W-1:0] q;
    v = '0;
    if (n == 0 || d == 0 || (n < 0) != (d < 0)) return 1'b0;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = {an, {hfe_pkg::FRAC_W{1'b0}}} / {{hfe_pkg::FRAC_W{1'b0}}, ad};
    v = (q > {{(hfe_pkg::SUM_W-hfe_pkg::QUO_W+hfe_pkg::FRAC_W){1'b0}}, QSAT}) ?
        QSAT : q[hfe_pkg::QUO_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic side_focal(logic signed [hfe_pkg::SUM_W-1:0] n1, d1, n2, d2,
                                      output logic [hfe_pkg::ROOT_W-1:0] f);
    logic [hfe_pkg::QUO_W-1:0] v1, v2, big, sml, pick;
    logic p1, p2;
    logic [hfe_pkg::SUM_W-1:0] a1, a2;
    f = '0;
    p1 = ratio(n1, d1, v1);
    p2 = ratio(n2, d2, v2);
    a1 = d1 < 0 ? -d1 : d1;
    a2 = d2 < 0 ? -d2 : d2;
    if (p1 && p2) begin
      big = v1 < v2 ? v2 : v1;
      sml = v1 < v2 ? v1 : v2;
      pick = a1 > a2 ? big : sml;
    end else if (p1) begin
      pick = v1;
    end else if (p2) begin
      pick = v2;
    end else begin
      return 1'b0;
    end
    f = isqrt({pick, {hfe_pkg::FRAC_W{1'b0}}});
    return 1'b1;
  endfunction

  function automatic focal_res_t predict_focal(logic [hfe_pkg::IN_W-1:0] e [8]);
    logic signed [hfe_pkg::SUM_W-1:0] n1, d1, n2, d2;
    logic [hfe_pkg::ROOT_W-1:0] f1, f0;
    logic ok1, ok0;
    focal_res_t r;
    d1 = prod(e[6], e[7]);
    d2 = prod(e[7], e[7]) - prod(e[6], e[6]);
    n1 = -(prod(e[0], e[1]) + prod(e[3], e[4]));
    n2 = prod(e[0], e[0]) + prod(e[3], e[3]) - prod(e[1], e[1]) - prod(e[4], e[4]);
    ok1 = side_focal(n1, d1, n2, d2, f1);
    d1 = prod(e[0], e[3]) + prod(e[1], e[4]);
    d2 = prod(e[0], e[0]) + prod(e[1], e[1]) - prod(e[3], e[3]) - prod(e[4], e[4]);
    n1 = -prod(e[2], e[5]);
    n2 = prod(e[5], e[5]) - prod(e[2], e[2]);
    ok0 = side_focal(n1, d1, n2, d2, f0);
    r.vld = ok1 && ok0;
    r.focal = r.vld ? isqrt(hfe_pkg::rad_t'(f1) * hfe_pkg::rad_t'(f0)) : '0;
    return r;
  endfunction

  logic [hfe_pkg::IN_W-1:0] ents [8];
  focal_res_t exp_r;

  always @(posedge clk) begin
    if (rst) begin
      errors  <= 0;
      pending <= 0;
      focal_q.delete();
    end else begin
      if (start && !busy) begin
        ents = '{h00, h01, h02, h10, h11, h12, h20, h21};
        focal_q.insert(focal_q.size(), predict_focal(ents));
      end
      if (done) begin
        if (focal_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result focal=%h", focal);
        end else begin
          exp_r = focal_q.pop_front();
          if (exp_r.focal !== focal || exp_r.vld !== valid_res) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: focal exp %h got %h, valid exp %b got %b",
                       exp_r.focal, focal, exp_r.vld, valid_res);
          end
        end
      end
      pending <= focal_q.size();
    end
  end
endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives random and corner homographies into the focal estimate unit; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, valid_res;
  logic [hfe_pkg::ROOT_W-1:0] focal;
  logic signed [hfe_pkg::IN_W-1:0] h00 = '0, h01 = '0, h02 = '0, h10 = '0;
  logic signed [hfe_pkg::IN_W-1:0] h11 = '0, h12 = '0, h20 = '0, h21 = '0;
  int errors, pending;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  homography_focal_estimate_unit dut (.*);
  hfe_checker chk (.*);

  localparam logic [hfe_pkg::IN_W-1:0] ONE = 64'h0000_0100_0000_0000;

  // pick an entry: corners, values near one or zero, values up to one in magnitude, or fully random
  function automatic logic [hfe_pkg::IN_W-1:0] rand_entry();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return '0;
      3, 4: return ONE + {{32{1'b0}}, $urandom()} - 64'h8000_0000 +
                   ($urandom_range(0, 1) ? 64'hFFFF_FF00_0000_0000 : 0);
      5: return {{24{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 8'($urandom()), 32'($urandom())};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // hold the transaction until accepted
  task automatic send(input logic [hfe_pkg::IN_W-1:0] e [8]);
    @(negedge clk);
    start <= 1'b1;
    {h00, h01, h02, h10, h11, h12, h20, h21} <= {e[0], e[1], e[2], e[3],
                                                  e[4], e[5], e[6], e[7]};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [hfe_pkg::IN_W-1:0] e [8];
    int burst;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: zeros, extremes, identity-like, zero denominators, tiny values
    e = '{default: '0}; send(e);
    e = '{default: 64'h8000_0000_0000_0000}; send(e);
    e = '{default: 64'h7FFF_FFFF_FFFF_FFFF}; send(e);
    e = '{ONE, 0, 0, 0, ONE, 0, 0, 0}; send(e);
    e = '{ONE, ONE, ONE, ONE, -ONE, -ONE, ONE, ONE}; send(e);
    e = '{2*ONE, ONE, 64'd1, ONE, 64'd3, -64'd1, 0, 64'd5}; send(e);
    e = '{ONE, 2*ONE, 64'd100, -ONE, 3*ONE, 64'd70, 64'd1, 64'd2}; send(e);
    e = '{64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 64'h8000_0000_0000_0000, 64'd1,
          64'd2, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 64'd1}; send(e);
    e = '{64'd1, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 64'd1, -64'd1, 64'd1, 64'd2}; send(e);
    e = '{3*ONE, ONE, 5*ONE, -ONE, 2*ONE, 7*ONE, ONE, 3*ONE}; send(e);
    for (int i = 0; i < 8; i++) begin
      e = '{default: ONE}; e[i] = 64'h8000_0000_0000_0000; send(e);
    end

    // drain completely once before the random part
    pause(1);
    while (pending != 0) @(negedge clk);

    for (int n = 0; n < 1200; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < 1200; k++, n++) begin
        foreach (e[j]) e[j] = rand_entry();
        send(e);
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 20));
    end
    pause(1);

    while (pending != 0) @(posedge clk);
    repeat (hfe_pkg::PIPE_LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* files.f */
design/hfe_pkg.sv
design/hfe_div.sv
design/hfe_sqrt.sv
design/homography_focal_estimate_unit.sv
sim/hfe_checker.sv
sim/tb.sv
